// ===== hdl/spq_pkg.sv =====
package spq_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int PRIO_W = 16;

    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_DEQUEUE = 2'd1;
    localparam logic [1:0] OP_PEEK    = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PEEK,
        S_DEQ_HEAD,
        S_DEQ_SHIFT,
        S_ENQ_CMP,
        S_ENQ_PUT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic        [PRIO_W-1:0] prio;
        logic signed [DATA_W-1:0] data;
    } entry_t;

endpackage

// ===== hdl/sorted_priority_queue.sv =====
// Bounded priority queue of spq_pkg::DEPTH entries, held in one simple dual-port
// RAM (one write and one registered read per cycle) sorted by priority with the
// head at slot 0. Equal priorities leave in arrival order. Each request (op 0
// enqueue, 1 dequeue, 2 peek) gives exactly one result transfer with head_data
// and status (0 ok, 1 full on enqueue, 2 empty on dequeue or peek); head_data is
// zero unless a dequeue or peek succeeds, and op 3 is ignored with status ok.
// Requests are processed one at a time; the cost is set by the single RAM port
// pair, which moves one entry per cycle. With c entries stored, a dequeue shifts
// c - 1 entries toward the head, and an enqueue moves every entry of strictly
// lower priority back one slot, whether or not the new item ends up as the head.
// A result that finds the output register still held waits in the EMIT state,
// and stays there for as long as the receiver keeps stalling. The RAM needs no
// clearing after reset: only data from slots below the entry count is ever used.
module sorted_priority_queue
(
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        op,
    input  logic signed [spq_pkg::DATA_W-1:0] item_data,
    input  logic [spq_pkg::PRIO_W-1:0]        item_priority,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [spq_pkg::DATA_W-1:0] head_data,
    output logic [1:0]                        status
);
    import spq_pkg::*;

    // queue storage
    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    entry_t            mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    // control state
    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [ADDR_W-1:0]         ptr_reg, ptr_next;     // slot being filled on enqueue, read on dequeue
    entry_t                    key_reg, key_next;     // item being inserted
    logic signed [DATA_W-1:0]  res_data_reg, res_data_next;
    logic [1:0]                res_status_reg, res_status_next;

    // output register
    logic                      out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0]  head_data_reg, head_data_next;
    logic [1:0]                status_reg, status_next;

    // finish request from the sequencer
    logic                      fin;
    logic signed [DATA_W-1:0]  fin_data;
    logic [1:0]                fin_status;
    logic                      out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign head_data = head_data_reg;
    assign status    = status_reg;

    // RAM: one write port, one read port with registered data
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        key_next        = key_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = ptr_reg;
        mem_wdata       = key_reg;
        mem_raddr       = '0;
        fin             = 1'b0;
        fin_data        = '0;
        fin_status      = ST_OK;
        in_ready        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (op)
                        OP_ENQUEUE:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                fin        = 1'b1;
                                fin_status = ST_FULL;
                            end
                            else
                            begin
                                key_next.prio = item_priority;
                                key_next.data = item_data;
                                count_next    = count_reg + 1'b1;
                                ptr_next      = count_reg[ADDR_W-1:0];
                                // look at the current tail first
                                mem_raddr     = count_reg[ADDR_W-1:0] - 1'b1;
                                state_next    = (count_reg == '0) ? S_ENQ_PUT : S_ENQ_CMP;
                            end
                        end
                        OP_DEQUEUE:
                        begin
                            if (count_reg == '0)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                mem_raddr  = '0;
                                state_next = S_DEQ_HEAD;
                            end
                        end
                        OP_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_EMPTY;
                            end
                            else
                            begin
                                mem_raddr  = '0;
                                state_next = S_PEEK;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            S_PEEK:
            begin
                fin      = 1'b1;
                fin_data = rd_data_reg.data;
            end

            S_DEQ_HEAD:
            begin
                // count_reg already holds the post-dequeue count
                res_data_next = rd_data_reg.data;
                if (count_reg == '0)
                begin
                    fin      = 1'b1;
                    fin_data = rd_data_reg.data;
                end
                else
                begin
                    mem_raddr  = ADDR_W'(1);
                    ptr_next   = ADDR_W'(1);
                    state_next = S_DEQ_SHIFT;
                end
            end

            S_DEQ_SHIFT:
            begin
                // rd_data_reg holds slot ptr; move it one toward the head
                mem_we    = 1'b1;
                mem_waddr = ptr_reg - 1'b1;
                mem_wdata = rd_data_reg;
                if (CNT_W'(ptr_reg) == count_reg)
                begin
                    fin      = 1'b1;
                    fin_data = res_data_reg;
                end
                else
                begin
                    mem_raddr = ptr_reg + 1'b1;
                    ptr_next  = ptr_reg + 1'b1;
                end
            end

            S_ENQ_CMP:
            begin
                // rd_data_reg holds slot ptr-1
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                if (rd_data_reg.prio < key_reg.prio)
                begin
                    mem_wdata = rd_data_reg;
                    ptr_next  = ptr_reg - 1'b1;
                    if (ptr_reg == ADDR_W'(1))
                    begin
                        state_next = S_ENQ_PUT;
                    end
                    else
                    begin
                        mem_raddr = ptr_reg - ADDR_W'(2);
                    end
                end
                else
                begin
                    mem_wdata = key_reg;
                    fin       = 1'b1;
                end
            end

            S_ENQ_PUT:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = key_reg;
                fin       = 1'b1;
            end

            S_EMIT:
            begin
                fin        = 1'b1;
                fin_data   = res_data_reg;
                fin_status = res_status_reg;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // result goes straight to the output register, or waits in EMIT
        out_valid_next = out_valid_reg && !out_ready;
        head_data_next = head_data_reg;
        status_next    = status_reg;
        if (fin)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                head_data_next = fin_data;
                status_next    = fin_status;
                state_next     = S_IDLE;
            end
            else
            begin
                res_data_next   = fin_data;
                res_status_next = fin_status;
                state_next      = S_EMIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        key_reg        <= key_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        head_data_reg  <= head_data_next;
        status_reg     <= status_next;
    end

    // entry count stays within the queue depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // every RAM write lands inside the occupied region
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (CNT_W'(mem_waddr) < count_reg))
        else $error("RAM write outside occupied slots");

    // an accepted enqueue with room grows the queue by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && op == OP_ENQUEUE && count_reg != CNT_W'(DEPTH))
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("enqueue did not grow the queue");

    // failed requests report zero data
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (head_data == '0))
        else $error("nonzero data with error status");

    // no new request while one is still in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("request taken while busy");

endmodule

// ===== bench/sorted_priority_queue_test.sv =====
`timescale 1ns / 1ps

// Checks sorted_priority_queue against a behavioral queue model.
// A short directed run covers the empty, full and unused-op cases first.
// After that, three random phases run with different back-pressure settings.
// Every accepted result is compared with the oldest predicted one.
module sorted_priority_queue_test;

    import spq_pkg::*;

    // op code 3 has no function; the queue must leave its contents alone
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // random requests per back-pressure phase
    localparam int PHASE_ITEMS = 410;

    // one predicted result transfer
    typedef struct packed {
        logic signed [DATA_W-1:0] head;
        logic [1:0]               status;
    } queue_result_t;

    // Behavioral copy of the queue plus the list of results still owed by the DUT.
    class queue_scoreboard;
        logic signed [DATA_W-1:0] slot_data [DEPTH];
        logic [PRIO_W-1:0]        slot_prio [DEPTH];
        int                       fill;
        queue_result_t            owed [$];
        int                       errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        // Apply one accepted request to the model and queue up its result.
        function void note_request(logic [1:0] req_op, logic signed [DATA_W-1:0] req_data,
                                   logic [PRIO_W-1:0] req_prio);
            queue_result_t r;
            int            pos;
            int            i;
            r.head   = '0;
            r.status = ST_OK;
            case (req_op)
                OP_ENQUEUE:
                begin
                    if (fill >= DEPTH)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        // stable insert: goes behind every entry of equal or higher priority
                        pos = 0;
                        while (pos < fill && slot_prio[pos] >= req_prio)
                            pos++;
                        for (i = fill; i > pos; i--)
                        begin
                            slot_data[i] = slot_data[i-1];
                            slot_prio[i] = slot_prio[i-1];
                        end
                        slot_data[pos] = req_data;
                        slot_prio[pos] = req_prio;
                        fill++;
                    end
                end
                OP_DEQUEUE, OP_PEEK:
                begin
                    if (fill == 0)
                    begin
                        r.status = ST_EMPTY;
                    end
                    else
                    begin
                        r.head = slot_data[0];
                        if (req_op == OP_DEQUEUE)
                        begin
                            for (i = 1; i < fill; i++)
                            begin
                                slot_data[i-1] = slot_data[i];
                                slot_prio[i-1] = slot_prio[i];
                            end
                            fill--;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            owed.push_back(r);
        endfunction

        // Compare one accepted result transfer with the oldest owed result.
        function void check_result(logic signed [DATA_W-1:0] got_head, logic [1:0] got_status);
            queue_result_t exp_r;
            if (owed.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual head_data %0d status %0d",
                         $time, got_head, got_status);
                errors++;
            end
            else
            begin
                exp_r = owed.pop_front();
                if (got_head !== exp_r.head)
                begin
                    $display("%0t: head_data mismatch: expected %0d actual %0d",
                             $time, exp_r.head, got_head);
                    errors++;
                end
                if (got_status !== exp_r.status)
                begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, exp_r.status, got_status);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [1:0]               op = OP_ENQUEUE;
    logic signed [DATA_W-1:0] item_data = '0;
    logic [PRIO_W-1:0]        item_priority = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] head_data;
    logic [1:0]               status;

    // idle odds in percent, changed by the stimulus between phases
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    queue_scoreboard book = new();

    sorted_priority_queue dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .item_data     (item_data),
        .item_priority (item_priority),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .head_data     (head_data),
        .status        (status)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop: well beyond the slowest legal run (about 1250 requests, with
    // sender gaps and an 80% result stall).
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Result side: random back-pressure, check every completed transfer.
    // Inputs are sampled right after the edge, so they hold pre-edge values.
    initial
    begin
        forever
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
            @(posedge clk);
            if (out_valid && out_ready)
                book.check_result(head_data, status);
        end
    end

    // One request transfer, with an optional random gap in front of it.
    // The model is updated at the edge where the transfer completes.
    task automatic send_req(input logic [1:0] req_op, input logic signed [DATA_W-1:0] req_data,
                            input logic [PRIO_W-1:0] req_prio);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= req_op;
        item_data     <= req_data;
        item_priority <= req_prio;
        do
            @(posedge clk);
        while (!in_ready);
        book.note_request(req_op, req_data, req_prio);
    endtask

    // Hold off the request side until every owed result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0)
            @(posedge clk);
    endtask

    // Priorities mostly from a narrow set so ties (arrival order) are common.
    function automatic logic [PRIO_W-1:0] pick_prio();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return PRIO_W'($urandom_range(3));
            5:       return 16'h8000;
            default: return PRIO_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_data();
        case ($urandom_range(15))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -32'sd1;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // Random request stream. Alternates between filling and draining bursts
    // so the queue swings between empty and full many times per phase.
    task automatic random_phase(input int count);
        int  n;
        int  roll;
        bit  filling;
        logic [1:0] req_op;
        filling = 1'b1;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(29) == 0)
                filling = !filling;
            // now and then let the DUT run completely dry before the next request
            if ($urandom_range(59) == 0)
                drain_results();
            roll = $urandom_range(99);
            if (roll < 5)
                req_op = OP_UNUSED;
            else if (roll < 15)
                req_op = OP_PEEK;
            else if (roll < (filling ? 75 : 30))
                req_op = OP_ENQUEUE;
            else
                req_op = OP_DEQUEUE;
            send_req(req_op, pick_data(), pick_prio());
        end
    endtask

    initial
    begin
        int i;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part, no idling ---
        // empty queue: peek, dequeue, and the unused op
        send_req(OP_PEEK, 32'sd11, 16'd1);
        send_req(OP_DEQUEUE, 32'sd12, 16'd2);
        send_req(OP_UNUSED, 32'sh7FFF_FFFF, 16'hFFFF);
        // single entry in, then dequeue the last remaining entry
        send_req(OP_ENQUEUE, 32'sh8000_0000, 16'h0000);
        send_req(OP_DEQUEUE, 32'sd0, 16'd0);
        // fill to capacity: four priority levels with ties, extreme data first
        for (i = 0; i < DEPTH; i++)
        begin
            send_req(OP_ENQUEUE,
                     (i == 0) ? 32'sh7FFF_FFFF : (i == 1) ? 32'sh8000_0000 : DATA_W'($urandom),
                     PRIO_W'(i % 4) * 16'h5555);
        end
        // full queue: rejected enqueue, unused op, then head reads
        send_req(OP_ENQUEUE, 32'sd99, 16'hFFFF);
        send_req(OP_UNUSED, 32'sd0, 16'd0);
        send_req(OP_PEEK, 32'sd0, 16'd0);
        send_req(OP_DEQUEUE, 32'sd0, 16'd0);
        drain_results();

        // --- random part: three back-pressure settings ---
        send_idle_pct  = 34;
        recv_stall_pct = 80;
        random_phase(PHASE_ITEMS);
        drain_results();

        send_idle_pct  = 80;
        recv_stall_pct = 34;
        random_phase(PHASE_ITEMS);
        drain_results();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_phase(PHASE_ITEMS);

        // wind down: wait for the last results, then watch for stray transfers
        drain_results();
        repeat (40) @(posedge clk);

        if (book.pending() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, book.pending());
            book.errors++;
        end
        if (book.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
